// ----- rtl/shvsd_pkg.sv -----
// shvsd_pkg: types, stitch kind codes and escape bytes shared by the stitch decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package shvsd_pkg;

  // stitch kind codes on the result channel
  localparam logic [2:0] KIND_NORMAL = 3'd0;
  localparam logic [2:0] KIND_JUMP   = 3'd1;
  localparam logic [2:0] KIND_STOP   = 3'd2;
  localparam logic [2:0] KIND_TRIM   = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  // escape pair bytes
  localparam logic [7:0] ESC_LEAD  = 8'h80;
  localparam logic [7:0] ESC_WIDE  = 8'h01;
  localparam logic [7:0] ESC_CLEAR = 8'h02;
  localparam logic [7:0] ESC_SKIP  = 8'h03;

  // decoded entry queue between decoder and output register
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic [2:0]         stitch_kind;
    logic               last_result;
  } out_item_t;

  // one decoded input item: an optional move and an optional end stitch after it
  typedef struct packed {
    logic      has_move;
    logic      eos;
    out_item_t move;
  } dec_entry_t;

  typedef enum logic [2:0] {
    PH_X   = 3'd0,
    PH_Y   = 3'd1,
    PH_WXH = 3'd2,
    PH_WXL = 3'd3,
    PH_WYH = 3'd4,
    PH_WYL = 3'd5
  } phase_t;

endpackage

`default_nettype wire

// ----- rtl/shvsd_decode.sv -----
// shvsd_decode: byte phase machine that pairs bytes, handles escapes and wide moves
// depends on shvsd_pkg
`default_nettype none

module shvsd_decode (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire shvsd_pkg::in_item_t  item,
  output logic                      push,
  output shvsd_pkg::dec_entry_t     entry
);
  import shvsd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] wide_x_r, wide_x_nxt;
  logic [7:0]  wide_yh_r, wide_yh_nxt;
  logic        pair_seen_r, pair_seen_nxt;
  logic        jump_r, jump_nxt;

  logic [7:0] b;
  logic       is_esc;

  assign b      = item.stream_byte;
  assign is_esc = (held_r == ESC_LEAD) &&
                  (b == ESC_WIDE || b == ESC_CLEAR || b == ESC_SKIP);

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    wide_x_nxt    = wide_x_r;
    wide_yh_nxt   = wide_yh_r;
    pair_seen_nxt = pair_seen_r;
    jump_nxt      = jump_r;
    case (phase_r)
      PH_X: begin
        held_nxt  = b;
        phase_nxt = PH_Y;
      end
      PH_Y: begin
        pair_seen_nxt = 1'b1;
        phase_nxt     = PH_X;
        if (held_r == ESC_LEAD && b == ESC_CLEAR) begin
          jump_nxt = 1'b0;
        end else if (held_r == ESC_LEAD && b == ESC_WIDE) begin
          phase_nxt = PH_WXH;
        end
      end
      PH_WXH: begin
        wide_x_nxt = {b, 8'h00};
        phase_nxt  = PH_WXL;
      end
      PH_WXL: begin
        wide_x_nxt = {wide_x_r[15:8], b};
        phase_nxt  = PH_WYH;
      end
      PH_WYH: begin
        wide_yh_nxt = b;
        phase_nxt   = PH_WYL;
      end
      PH_WYL: begin
        jump_nxt  = 1'b1;
        phase_nxt = PH_X;
      end
      default: begin
        phase_nxt = PH_X;
      end
    endcase
    // end of stream puts everything back to the reset state
    if (item.end_of_stream) begin
      phase_nxt     = PH_X;
      held_nxt      = '0;
      wide_x_nxt    = '0;
      wide_yh_nxt   = '0;
      pair_seen_nxt = 1'b0;
      jump_nxt      = 1'b0;
    end
  end

  // outputs
  always_comb begin
    entry                  = '0;
    entry.eos              = item.end_of_stream;
    entry.move.last_result = 1'b0;
    case (phase_r)
      PH_Y: begin
        if (!is_esc) begin
          entry.has_move    = 1'b1;
          entry.move.move_x = $signed({{8{held_r[7]}}, held_r});
          entry.move.move_y = $signed({{8{b[7]}}, b});
          if (held_r == 8'h00 && b == 8'h00 && pair_seen_r) begin
            entry.move.stitch_kind = KIND_STOP;
          end else if (jump_r) begin
            entry.move.stitch_kind = KIND_JUMP;
          end else begin
            entry.move.stitch_kind = KIND_NORMAL;
          end
        end
      end
      PH_WYL: begin
        entry.has_move         = 1'b1;
        entry.move.move_x      = $signed(wide_x_r);
        entry.move.move_y      = $signed({wide_yh_r, b});
        entry.move.stitch_kind = KIND_TRIM;
      end
      default: begin
        entry.has_move = 1'b0;
      end
    endcase
  end

  assign push = step && (entry.has_move || entry.eos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_X;
      held_r      <= '0;
      wide_x_r    <= '0;
      wide_yh_r   <= '0;
      pair_seen_r <= 1'b0;
      jump_r      <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      wide_x_r    <= wide_x_nxt;
      wide_yh_r   <= wide_yh_nxt;
      pair_seen_r <= pair_seen_nxt;
      jump_r      <= jump_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/shvsd_out_queue.sv -----
// shvsd_out_queue: queue of decoded entries and the result register that unpacks them
// depends on shvsd_pkg
`default_nettype none

module shvsd_out_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire shvsd_pkg::dec_entry_t entry,
  output logic                       full,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output shvsd_pkg::out_item_t       out_data
);
  import shvsd_pkg::*;

  dec_entry_t mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;
  logic                part_r;   // head entry move already sent, end stitch pending
  logic                out_valid_r;
  out_item_t           out_data_r;

  dec_entry_t head;
  logic       load, pop, send_move;
  out_item_t  end_item;

  assign head      = mem_r[rd_ptr_r];
  assign full      = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign load      = (count_r != '0) && (!out_valid_r || out_ready);
  assign send_move = head.has_move && !part_r;
  assign pop       = load && !(send_move && head.eos);

  always_comb begin
    end_item             = '0;
    end_item.stitch_kind = KIND_END;
    end_item.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      part_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + QUEUE_CW'(push) - QUEUE_CW'(pop);
      if (load) begin
        part_r      <= send_move && head.eos;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= send_move ? head.move : end_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/shv_stitch_stream_decoder_top.sv -----
// shv_stitch_stream_decoder_top: stitch-section byte stream to relative stitch moves
// depends on shvsd_pkg, shvsd_decode, shvsd_out_queue
//
//   channel | ports                          | direction | payload
//   --------+--------------------------------+-----------+---------------------------------
//   in      | in_valid, in_ready, in_data    | input     | stream_byte, end_of_stream
//   out     | out_valid, out_ready, out_data | output    | move_x, move_y, stitch_kind,
//           |                                |           | last_result
//
// one byte is accepted per cycle while the queue is not full; each byte is decoded from
// its input register once the queue has room and reaches out_data via the result register
// a byte that gives a move and also ends the stream yields two results from the single
// result register; the four-entry queue absorbs that without stopping input
// reset (rst_n low at a clock edge) clears the phase machine, jump mode and the queue
// out_ready low backs up the queue; in_ready drops only once the queue is full
`default_nettype none

module shv_stitch_stream_decoder_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire shvsd_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output shvsd_pkg::out_item_t      out_data
);
  import shvsd_pkg::*;

  // input register
  logic     in_v_r;
  in_item_t in_r;

  logic       step;       // registered byte goes through the decoder this cycle
  logic       q_full;
  logic       push;
  dec_entry_t entry;

  assign step     = in_v_r && !q_full;
  assign in_ready = !in_v_r || !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  // byte phase machine
  shvsd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_r),
    .push  (push),
    .entry (entry)
  );

  // queue and result register
  shvsd_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .entry     (entry),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // the end stitch always closes the stream
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stitch_kind == KIND_END |-> out_data.last_result)
    else $error("end stitch without last_result");

  // closing stitch carries no move
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_result |->
      out_data.move_x == 16'sd0 && out_data.move_y == 16'sd0 &&
      out_data.stitch_kind == KIND_END)
    else $error("last_result on a result other than the end stitch");

  // a byte waiting on a full queue stays in the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !step |=> in_v_r && $stable(in_r))
    else $error("stalled input byte lost");

  // an end-of-stream byte always leaves a queue entry
  assert property (@(posedge clk) disable iff (!rst_n)
    step && in_r.end_of_stream |-> push)
    else $error("end of stream byte gave no entry");

endmodule

`default_nettype wire

// ----- dv/shv_stitch_stream_decoder_top_tb.sv -----
// shv_stitch_stream_decoder_top_tb: self-checking bench for the stitch stream decoder
// depends on shvsd_pkg and shv_stitch_stream_decoder_top; byte items go in, stitch items
// come out and are checked against an in-bench decoder model
`default_nettype none

module shv_stitch_stream_decoder_top_tb;
  import shvsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned ITEM_TARGET = 1700;
  localparam int unsigned TAIL_CYCLES = 20;

  // one byte item waiting to be sent, with the idle cycles that come before it
  typedef struct {
    in_item_t    data;
    int unsigned gap;
    bit          drain;
  } byte_feed_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  byte_feed_t  byte_feed[$];
  out_item_t   expected_stitches[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // sender and receiver pacing
  int unsigned send_idle = 0;
  int unsigned sink_hold = 0;
  int unsigned sink_calm = 0;
  bit          burst = 1'b0;
  bit          drain_next = 1'b0;

  // decoder model state
  phase_t      dec_phase;
  logic [7:0]  held_x;
  logic [15:0] wide_x;
  logic [7:0]  wide_y_hi;
  logic        pair_done;
  logic        jump_on;
  out_item_t   want;

  shv_stitch_stream_decoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------

  task automatic clear_decoder();
    dec_phase = PH_X;
    held_x    = '0;
    wide_x    = '0;
    wide_y_hi = '0;
    pair_done = 1'b0;
    jump_on   = 1'b0;
  endtask

  task automatic push_stitch(input logic [15:0] x, input logic [15:0] y,
                             input logic [2:0] kind, input logic last);
    out_item_t s;
    s.move_x      = x;
    s.move_y      = y;
    s.stitch_kind = kind;
    s.last_result = last;
    expected_stitches.push_back(s);
  endtask

  // one accepted byte: advance the phase machine, queue the stitches it yields
  task automatic decode_byte(input in_item_t it);
    logic [7:0] b;
    logic       first_pair;
    logic [2:0] kind;
    b = it.stream_byte;
    case (dec_phase)
      PH_X: begin
        held_x    = b;
        dec_phase = PH_Y;
      end
      PH_Y: begin
        first_pair = !pair_done;
        pair_done  = 1'b1;
        dec_phase  = PH_X;
        if (held_x == ESC_LEAD && b == ESC_SKIP) begin
          // skip pair, nothing emitted
        end else if (held_x == ESC_LEAD && b == ESC_CLEAR) begin
          jump_on = 1'b0;
        end else if (held_x == ESC_LEAD && b == ESC_WIDE) begin
          dec_phase = PH_WXH;
        end else begin
          // plain move, also the escape lead with an unknown second byte
          kind = jump_on ? KIND_JUMP : KIND_NORMAL;
          if (held_x == 8'h00 && b == 8'h00 && !first_pair) kind = KIND_STOP;
          push_stitch({{8{held_x[7]}}, held_x}, {{8{b[7]}}, b}, kind, 1'b0);
        end
      end
      PH_WXH: begin
        wide_x[15:8] = b;
        dec_phase    = PH_WXL;
      end
      PH_WXL: begin
        wide_x[7:0] = b;
        dec_phase   = PH_WYH;
      end
      PH_WYH: begin
        wide_y_hi = b;
        dec_phase = PH_WYL;
      end
      default: begin
        push_stitch(wide_x, {wide_y_hi, b}, KIND_TRIM, 1'b0);
        jump_on   = 1'b1;
        dec_phase = PH_X;
      end
    endcase
    // end of stream: end stitch after whatever this byte gave, then a fresh stream
    if (it.end_of_stream) begin
      push_stitch('0, '0, KIND_END, 1'b1);
      clear_decoder();
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents the byte feed, idles for each item's drawn gap
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      send_idle = 0;
      clear_decoder();
    end else if (!(in_valid && !in_ready)) begin
      // channel free this cycle: either idle or the held item was just taken
      if (in_valid) decode_byte(in_data);
      if (byte_feed.size() == 0) begin
        in_valid <= 1'b0;
      end else if (byte_feed[0].drain && expected_stitches.size() != 0) begin
        // hold off until every outstanding stitch has been seen
        in_valid <= 1'b0;
      end else if (send_idle < byte_feed[0].gap) begin
        send_idle++;
        in_valid <= 1'b0;
      end else begin
        in_data   <= byte_feed[0].data;
        in_valid  <= 1'b1;
        send_idle = 0;
        void'(byte_feed.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each taken stitch, stalls out_ready per item
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input int exp_v, input int got_v);
    errors++;
    $display("%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_stitches.size() == 0) begin
          errors++;
          $display("%0t: unexpected stitch expected none got x=%0d y=%0d kind=%0d last=%0d",
                   $time, out_data.move_x, out_data.move_y, out_data.stitch_kind,
                   out_data.last_result);
        end else begin
          want = expected_stitches.pop_front();
          if (out_data.move_x !== want.move_x)
            note_mismatch("move_x", want.move_x, out_data.move_x);
          if (out_data.move_y !== want.move_y)
            note_mismatch("move_y", want.move_y, out_data.move_y);
          if (out_data.stitch_kind !== want.stitch_kind)
            note_mismatch("stitch_kind", want.stitch_kind, out_data.stitch_kind);
          if (out_data.last_result !== want.last_result)
            note_mismatch("last_result", want.last_result, out_data.last_result);
        end
        // stall before the next item, with occasional stretches of none
        if (sink_calm > 0) begin
          sink_calm--;
          sink_hold = 0;
        end else begin
          if ($urandom_range(0, 39) == 0) sink_calm = $urandom_range(10, 40);
          sink_hold = $urandom_range(0, 4);
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic feed(input logic [7:0] b, input bit eos);
    byte_feed_t f;
    f.data.stream_byte   = b;
    f.data.end_of_stream = eos;
    f.gap                = burst ? 0 : $urandom_range(0, 4);
    f.drain              = drain_next;
    drain_next           = 1'b0;
    byte_feed.push_back(f);
  endtask

  // random byte biased toward the sign and range edges
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one stream: mostly well-formed tokens, sometimes noise or a broken tail,
  // always closed by an end-of-stream byte
  task automatic add_random_stream();
    logic [7:0] sb[$];
    int         ntok;
    int         pick;
    int         cut;
    burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 19) == 0) drain_next = 1'b1;
    if ($urandom_range(0, 6) == 0) begin
      // noise
      ntok = $urandom_range(1, 12);
      repeat (ntok) sb.push_back(8'($urandom_range(0, 255)));
    end else begin
      ntok = $urandom_range(1, 30);
      repeat (ntok) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          sb.push_back(pick_byte());
          sb.push_back(pick_byte());
        end else if (pick < 60) begin
          sb.push_back(8'h00);
          sb.push_back(8'h00);
        end else if (pick < 67) begin
          sb.push_back(ESC_LEAD);
          sb.push_back(ESC_SKIP);
        end else if (pick < 76) begin
          sb.push_back(ESC_LEAD);
          sb.push_back(ESC_CLEAR);
        end else if (pick < 93) begin
          sb.push_back(ESC_LEAD);
          sb.push_back(ESC_WIDE);
          repeat (4) sb.push_back(pick_byte());
        end else begin
          // escape lead with an unknown second byte
          sb.push_back(ESC_LEAD);
          sb.push_back(8'($urandom_range(4, 255)));
        end
      end
      // broken tails: a lone x byte, or a wide move cut short
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        sb.push_back(pick_byte());
      end else if (pick == 1) begin
        sb.push_back(ESC_LEAD);
        sb.push_back(ESC_WIDE);
        cut = $urandom_range(0, 3);
        repeat (cut) sb.push_back(pick_byte());
      end
    end
    foreach (sb[i]) feed(sb[i], i == sb.size() - 1);
  endtask

  initial begin
    // directed: first zero pair is a move, the next one a stop
    feed(8'h00, 1'b0); feed(8'h00, 1'b0);
    feed(8'h00, 1'b0); feed(8'h00, 1'b0);
    // skip pair
    feed(ESC_LEAD, 1'b0); feed(ESC_SKIP, 1'b0);
    // wide move with x = -32768 and y = +32767, sets jump mode
    feed(ESC_LEAD, 1'b0); feed(ESC_WIDE, 1'b0);
    feed(8'h80, 1'b0); feed(8'h00, 1'b0); feed(8'h7F, 1'b0); feed(8'hFF, 1'b0);
    // jump move at the byte extremes
    feed(8'h7F, 1'b0); feed(8'h80, 1'b0);
    // jump mode cleared
    feed(ESC_LEAD, 1'b0); feed(ESC_CLEAR, 1'b0);
    // unknown escape is an ordinary move of x = -128
    feed(ESC_LEAD, 1'b0); feed(8'h05, 1'b0);
    // move on the final byte, then the end stitch
    feed(8'hFF, 1'b0); feed(8'h01, 1'b1);
    // odd trailing byte dropped
    feed(8'h12, 1'b1);
    // wide move cut off by end of stream
    feed(ESC_LEAD, 1'b0); feed(ESC_WIDE, 1'b0); feed(8'h34, 1'b1);

    // random streams; the first one waits for the directed part to drain
    drain_next = 1'b1;
    while (byte_feed.size() < ITEM_TARGET) add_random_stream();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // all items sent, all stitches seen, then a quiet tail for stray results
    while (byte_feed.size() != 0 || in_valid) @(posedge clk);
    while (expected_stitches.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- shv_stitch_stream_decoder_top.f -----
rtl/shvsd_pkg.sv
rtl/shvsd_decode.sv
rtl/shvsd_out_queue.sv
rtl/shv_stitch_stream_decoder_top.sv
dv/shv_stitch_stream_decoder_top_tb.sv
